>>> rtl/core/tem_pkg.sv
`timescale 1ns / 1ps

package tem_pkg;

  localparam int NUM_LANES_DEF = 14;

  localparam int CFG_W        = 14;
  localparam int LANE_FIELD_W = 4;
  localparam int CH_W         = 16;
  localparam int CO_W         = 32;
  localparam int FI_W         = 16;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 14'h3FFF;

  localparam logic REQ_EVENT = 1'b0;
  localparam logic REQ_END   = 1'b1;

  localparam logic STATUS_EVENT  = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic load_in;
    logic apply;
    logic load_reject;
    logic scan_start;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic drain_ok;
    logic scan_done;
    logic out_last;
  } stat_t;

endpackage

>>> rtl/core/tem_ctrl.sv
`timescale 1ns / 1ps

module tem_ctrl import tem_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  out_stall,
  output logic  in_stall,
  output logic  out_valid,
  output cmd_t  cmd,
  input  stat_t stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_APPLY = 3'd1;
  localparam logic [2:0] S_COND  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_APPLY;
        end
      end
      S_APPLY: begin
        if (stat.reject) begin
          cmd.load_reject = 1'b1;
          state_next      = S_OUT;
        end else begin
          cmd.apply  = 1'b1;
          state_next = S_COND;
        end
      end
      S_COND: begin
        if (stat.drain_ok) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_result = 1'b1;
        state_next      = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (stat.out_last) begin
            state_next = S_IDLE;
          end else begin
            // more to drain: the released lane is already cleared
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/tem_datapath.sv
`timescale 1ns / 1ps

module tem_datapath import tem_pkg::*; #(
  parameter int NUM_LANES = NUM_LANES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    req_type,
  input  logic [LANE_FIELD_W-1:0] lane,
  input  logic [CH_W-1:0]         spectral_channel,
  input  logic [CO_W-1:0]         coarse_time,
  input  logic [FI_W-1:0]         fine_time,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  output logic                    status,
  output logic [LANE_FIELD_W-1:0] out_lane,
  output logic [CH_W-1:0]         out_spectral_channel,
  output logic [CO_W-1:0]         out_coarse_time,
  output logic [FI_W-1:0]         out_fine_time,
  output logic                    last
);

  localparam int IDX_W  = $clog2(NUM_LANES);
  localparam int WORD_W = CH_W + CO_W + FI_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LANES - 1);

  logic [NUM_LANES-1:0] active;
  logic [NUM_LANES-1:0] full;
  logic [NUM_LANES-1:0] ended;
  logic [NUM_LANES-1:0] cfg_expand;
  logic [NUM_LANES-1:0] reset_expand;
  logic [NUM_LANES-1:0] cand;
  logic [NUM_LANES-1:0] full_after;

  logic                    req_q;
  logic [LANE_FIELD_W-1:0] lane_q;
  logic [CH_W-1:0]         ch_q;
  logic [CO_W-1:0]         co_q;
  logic [FI_W-1:0]         fi_q;

  logic [WORD_W-1:0] mem [NUM_LANES];
  logic [WORD_W-1:0] rd_word;

  logic             rd_on;
  logic [IDX_W-1:0] rd_idx;
  logic             cmp_en;
  logic [IDX_W-1:0] cmp_idx;
  logic             best_valid;
  logic [IDX_W-1:0] best_idx;
  logic [CH_W-1:0]  best_ch;
  logic [CO_W-1:0]  best_co;
  logic [FI_W-1:0]  best_fi;

  logic [IDX_W-1:0] lane_idx;
  logic             lane_ok;
  logic [CH_W-1:0]  rd_ch;
  logic [CO_W-1:0]  rd_co;
  logic [FI_W-1:0]  rd_fi;
  logic             earlier;
  logic             take;
  logic             last_after;

  // lanes beyond the register width are never active
  genvar g;
  for (g = 0; g < NUM_LANES; g++) begin : g_mask
    if (g < CFG_W) begin : g_in
      assign cfg_expand[g]   = cfg_data[g];
      assign reset_expand[g] = ACTIVE_RESET[g];
    end else begin : g_out
      assign cfg_expand[g]   = 1'b0;
      assign reset_expand[g] = 1'b0;
    end
  end

  assign lane_idx = IDX_W'(lane_q);
  assign lane_ok  = (32'(lane_q) < NUM_LANES) && active[lane_idx];

  assign cand = active & full;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      full_after[i] = full[i] && (best_idx != IDX_W'(i));
    end
  end

  assign last_after = !((&(~active | full_after | ended)) && (|(active & full_after)));

  assign rd_ch = rd_word[WORD_W-1 -: CH_W];
  assign rd_co = rd_word[FI_W +: CO_W];
  assign rd_fi = rd_word[FI_W-1:0];

  // strict compare while scanning upward keeps the lower lane on a tie
  assign earlier = {rd_co, rd_fi} < {best_co, best_fi};
  assign take    = cmp_en && cand[cmp_idx] && (!best_valid || earlier);

  assign stat.reject    = (req_q == REQ_EVENT) &&
                          (!lane_ok || full[lane_idx] || ended[lane_idx]);
  assign stat.drain_ok  = (&(~active | full | ended)) && (|cand);
  assign stat.scan_done = cmp_en && (cmp_idx == LAST_IDX);
  assign stat.out_last  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= reset_expand;
      full       <= '0;
      ended      <= '0;
      rd_on      <= 1'b0;
      rd_idx     <= '0;
      cmp_en     <= 1'b0;
      cmp_idx    <= '0;
      best_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        active <= cfg_expand;
      end
      if (cmd.apply && lane_ok) begin
        if (req_q == REQ_EVENT) begin
          full[lane_idx] <= 1'b1;
        end else begin
          ended[lane_idx] <= 1'b1;
        end
      end
      if (cmd.load_result) begin
        full[best_idx] <= 1'b0;
      end
      if (cmd.scan_start) begin
        rd_on      <= 1'b1;
        rd_idx     <= '0;
        cmp_en     <= 1'b0;
        best_valid <= 1'b0;
      end else begin
        cmp_en <= rd_on;
        if (rd_on) begin
          cmp_idx <= rd_idx;
          if (rd_idx == LAST_IDX) begin
            rd_on <= 1'b0;
          end else begin
            rd_idx <= rd_idx + IDX_W'(1);
          end
        end
        if (take) begin
          best_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_q  <= req_type;
      lane_q <= lane;
      ch_q   <= spectral_channel;
      co_q   <= coarse_time;
      fi_q   <= fine_time;
    end
    if (cmd.apply && lane_ok && (req_q == REQ_EVENT)) begin
      mem[lane_idx] <= {ch_q, co_q, fi_q};
    end
    if (rd_on) begin
      rd_word <= mem[rd_idx];
    end
    if (take) begin
      best_idx <= cmp_idx;
      best_ch  <= rd_ch;
      best_co  <= rd_co;
      best_fi  <= rd_fi;
    end
    if (cmd.load_reject) begin
      status               <= STATUS_REJECT;
      out_lane             <= lane_q;
      out_spectral_channel <= '0;
      out_coarse_time      <= '0;
      out_fine_time        <= '0;
      last                 <= 1'b1;
    end else if (cmd.load_result) begin
      status               <= STATUS_EVENT;
      out_lane             <= LANE_FIELD_W'(best_idx);
      out_spectral_channel <= best_ch;
      out_coarse_time      <= best_co;
      out_fine_time        <= best_fi;
      last                 <= last_after;
    end
  end

endmodule

>>> rtl/core/timestamp_event_merge_unit.sv
`timescale 1ns / 1ps

// Merges events from NUM_LANES detector lanes, each with a one-entry buffer, into one
// stream ordered by coarse then fine time, ties going to the lower lane. An item that
// releases nothing passes the load, apply and condition states; a rejected event is
// loaded and held in the output state until the output handshake. Each released event
// is found by a sequential scan of the lane buffer memory (one read per cycle) for the
// earliest held entry, then held for the output handshake. Input is taken only when
// the previous item has delivered all of its results. active_lanes may be written in
// any cycle (cfg_ready is always high) but should only change while the block is idle.

module timestamp_event_merge_unit import tem_pkg::*; #(
  parameter int NUM_LANES = NUM_LANES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        active_lanes,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    req_type,
  input  logic [LANE_FIELD_W-1:0] lane,
  input  logic [CH_W-1:0]         spectral_channel,
  input  logic [CO_W-1:0]         coarse_time,
  input  logic [FI_W-1:0]         fine_time,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    status,
  output logic [LANE_FIELD_W-1:0] out_lane,
  output logic [CH_W-1:0]         out_spectral_channel,
  output logic [CO_W-1:0]         out_coarse_time,
  output logic [FI_W-1:0]         out_fine_time,
  output logic                    last
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  tem_datapath #(
    .NUM_LANES (NUM_LANES)
  ) u_datapath (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_valid            (cfg_valid),
    .cfg_data             (active_lanes),
    .req_type             (req_type),
    .lane                 (lane),
    .spectral_channel     (spectral_channel),
    .coarse_time          (coarse_time),
    .fine_time            (fine_time),
    .cmd                  (cmd),
    .stat                 (stat),
    .status               (status),
    .out_lane             (out_lane),
    .out_spectral_channel (out_spectral_channel),
    .out_coarse_time      (out_coarse_time),
    .out_fine_time        (out_fine_time),
    .last                 (last)
  );

endmodule
